@@ src/fta_pkg.sv @@
// Shared types and constants for the float to two-decimal ASCII formatter.
`timescale 1ns / 1ps

package fta_pkg;

  // ASCII codes used in the output line.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  // Largest hundredths count; it prints as 9.99.
  localparam logic [9:0] HUND_MAX = 10'd999;

  // Exponent codes of interest.
  localparam logic [7:0] EXP_SPECIAL = 8'hFF;
  localparam logic [7:0] EXP_ZERO    = 8'h00;
  localparam logic [7:0] EXP_TOO_BIG = 8'd131;
  localparam logic [7:0] EXP_MIN_VIS = 8'd118;
  localparam logic [7:0] EXP_SHIFT   = 8'd149;

  // Byte positions within one output line.
  localparam logic [2:0] POS_MINUS = 3'd0;
  localparam logic [2:0] POS_INT   = 3'd1;
  localparam logic [2:0] POS_DOT   = 3'd2;
  localparam logic [2:0] POS_TENTH = 3'd3;
  localparam logic [2:0] POS_HUND  = 3'd4;
  localparam logic [2:0] POS_CR    = 3'd5;
  localparam logic [2:0] POS_LF    = 3'd6;

  // Rounded value handed from the converter to the byte emitter.
  typedef struct packed {
    logic       neg;
    logic       ovf;
    logic [9:0] hund;
  } fta_num_t;

endpackage

@@ src/fta_convert.sv @@
// Two-stage converter: input register, float to rounded hundredths, result register.
`timescale 1ns / 1ps

module fta_convert (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [31:0]   float_bits,
  output logic          num_valid,
  input  logic          num_stall,
  output fta_pkg::fta_num_t num
);
  import fta_pkg::*;

  logic        valid_a;
  logic [31:0] bits_a;
  logic        valid_b;
  fta_num_t    num_b;
  logic        stall_a;
  logic        stall_b;

  logic        sign;
  logic [7:0]  expo;
  logic [22:0] frac;
  logic [23:0] mant;
  logic [30:0] prod;
  logic [7:0]  shift_m1;
  logic [11:0] trunc;
  logic [12:0] rounded;
  fta_num_t    conv;

  // Stall chain: a stage holds while it is full and the next one holds.
  assign stall_b  = valid_b && num_stall;
  assign stall_a  = valid_a && stall_b;
  assign in_stall = stall_a;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (!stall_a) begin
      valid_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !stall_a) begin
      bits_a <= float_bits;
    end
  end

  // Field split and exact product of the significand by 100.
  assign sign     = bits_a[31];
  assign expo     = bits_a[30:23];
  assign frac     = bits_a[22:0];
  assign mant     = {1'b1, frac};
  assign prod     = {mant, 6'd0} + {1'b0, mant, 5'd0} + {5'd0, mant, 2'd0};
  assign shift_m1 = EXP_SHIFT - expo;
  assign trunc    = 12'(prod >> shift_m1[4:0]);
  assign rounded  = ({1'b0, trunc} + 13'd1) >> 1;

  // Round half-up to hundredths and saturate what does not fit one digit.
  always_comb begin
    conv.neg  = sign && (expo != EXP_ZERO)
                && !((expo == EXP_SPECIAL) && (frac != 23'd0));
    conv.ovf  = 1'b0;
    conv.hund = 10'd0;
    if (expo == EXP_SPECIAL || expo >= EXP_TOO_BIG) begin
      conv.ovf  = 1'b1;
      conv.hund = HUND_MAX;
    end else if (expo >= EXP_MIN_VIS) begin
      if (rounded > 13'(HUND_MAX)) begin
        conv.ovf  = 1'b1;
        conv.hund = HUND_MAX;
      end else begin
        conv.hund = rounded[9:0];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else if (!stall_b) begin
      valid_b <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_a && !stall_b) begin
      num_b <= conv;
    end
  end

  assign num_valid = valid_b;
  assign num       = num_b;

endmodule

@@ src/fta_emit.sv @@
// Byte emitter: splits hundredths into digits and sends the text line one byte per transfer.
`timescale 1ns / 1ps

module fta_emit (
  input  logic          clk,
  input  logic          rst,
  input  logic          num_valid,
  output logic          num_stall,
  input  fta_pkg::fta_num_t num,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    text_byte,
  output logic          last_byte,
  output logic          overflow
);
  import fta_pkg::*;

  logic        busy;
  logic [2:0]  pos;
  logic        ovf;
  logic [3:0]  digit_int;
  logic [6:0]  rest;

  logic        xfer;
  logic        at_end;
  logic        take;
  logic [3:0]  load_int;
  logic [9:0]  load_prod;
  logic [6:0]  load_rest;
  logic [13:0] tens_prod;
  logic [3:0]  digit_tenth;
  logic [6:0]  tens_times10;
  logic [6:0]  digit_hund_w;

  assign xfer      = busy && !out_stall;
  assign at_end    = (pos == POS_LF);
  assign num_stall = busy && !(xfer && at_end);
  assign take      = num_valid && !num_stall;

  // Leading digit and remainder below 100, by reciprocal multiply (exact below 1000).
  assign load_int  = 4'(({6'd0, num.hund} * 16'd41) >> 12);
  assign load_prod = {6'd0, load_int} * 10'd100;
  assign load_rest = 7'(num.hund - load_prod);

  // Line sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= POS_MINUS;
    end else if (!busy || (xfer && at_end)) begin
      busy <= num_valid;
      pos  <= num.neg ? POS_MINUS : POS_INT;
    end else if (xfer) begin
      pos  <= pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ovf       <= num.ovf;
      digit_int <= load_int;
      rest      <= load_rest;
    end
  end

  // Tenths and hundredths digits from the stored remainder.
  assign tens_prod    = {7'd0, rest} * 14'd103;
  assign digit_tenth  = 4'(tens_prod >> 10);
  assign tens_times10 = 7'({3'd0, digit_tenth} * 7'd10);
  assign digit_hund_w = rest - tens_times10;

  // Character select for the current position.
  always_comb begin
    unique case (pos)
      POS_MINUS: text_byte = CHAR_MINUS;
      POS_INT:   text_byte = CHAR_ZERO + {4'd0, digit_int};
      POS_DOT:   text_byte = CHAR_DOT;
      POS_TENTH: text_byte = CHAR_ZERO + {4'd0, digit_tenth};
      POS_HUND:  text_byte = CHAR_ZERO + {4'd0, digit_hund_w[3:0]};
      POS_CR:    text_byte = CHAR_CR;
      POS_LF:    text_byte = CHAR_LF;
      default:   text_byte = CHAR_LF;
    endcase
  end

  assign out_valid = busy;
  assign last_byte = at_end;
  assign overflow  = ovf;

endmodule

@@ src/float_to_ascii_two_decimals_core.sv @@
// Top level of the float to two-decimal ASCII text formatter.
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   input   | in_valid, in_stall, float_bits[31:0]       | in
//   output  | out_valid, out_stall, text_byte[7:0],      | out
//           | last_byte, overflow                        |
//
// Each value yields six or seven bytes, one per cycle while out_stall is
// low; the byte emitter that serializes them sets the rate. A value passes
// through the input register and the result register to the emitter, and
// the two converter registers take new values while a line is still being
// sent. Synchronous reset empties every stage. A stall on the output holds
// the current byte and backs up through the converter to in_stall.
`timescale 1ns / 1ps

module float_to_ascii_two_decimals_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] float_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  text_byte,
  output logic        last_byte,
  output logic        overflow
);
  import fta_pkg::*;

  logic     num_valid;
  logic     num_stall;
  fta_num_t num;

  // Float to rounded hundredths.
  fta_convert u_convert (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .float_bits (float_bits),
    .num_valid  (num_valid),
    .num_stall  (num_stall),
    .num        (num)
  );

  // Hundredths to a line of text.
  fta_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .num_valid  (num_valid),
    .num_stall  (num_stall),
    .num        (num),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .text_byte  (text_byte),
    .last_byte  (last_byte),
    .overflow   (overflow)
  );

endmodule

@@ src/fta_checker.sv @@
// Port-level checks for the formatter, bound to the top level.
`timescale 1ns / 1ps

module fta_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] text_byte,
  input logic       last_byte,
  input logic       overflow
);
  import fta_pkg::*;

  // Reset leaves no line in flight.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // The closing byte of a line is always the line feed.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_byte) |-> (text_byte == CHAR_LF))
    else $error("last byte is not a line feed");

  // The overflow flag is the same on back-to-back bytes of one line.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_byte) ##1 out_valid
      |-> (overflow == $past(overflow)))
    else $error("overflow changed within a line");

  // A stalled byte holds.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(text_byte)
                                  && $stable(last_byte)))
    else $error("stalled output changed");

endmodule

bind float_to_ascii_two_decimals_core fta_checker u_fta_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .text_byte (text_byte),
  .last_byte (last_byte),
  .overflow  (overflow)
);
